FILE: rtl/dqpos_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqpos_pkg
// Shared types and codes for the deque with positional insert and delete.
// ----------------------------------------------------------------------------
package dqpos_pkg;

    // Default number of stored words.
    localparam int DEPTH_DEFAULT = 16;

    // Command codes carried on the input beat.
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_INSERT_AT  = 3'd4,
        OP_DELETE_AT  = 3'd5
    } op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } st_t;

    // What a decoded command does to the store.
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_INS  = 2'd1,
        KIND_DEL  = 2'd2
    } kind_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_PUT,
        S_DEL_RD,
        S_DEL_CAP,
        S_SH_RD,
        S_SH_WR,
        S_DEL_END,
        S_EMIT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the incoming command
        logic rd_dn;   // read the entry below the pointer
        logic wr_dn;   // write read data at the pointer, step down
        logic put;     // write the new word at the target, count up
        logic rd_tgt;  // read the entry at the target
        logic cap;     // capture read data as the removed word
        logic rd_up;   // read the entry above the pointer
        logic wr_up;   // write read data at the pointer, step up
        logic dec_cnt; // count down
        logic emit;    // load the result register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        kind_t kind;     // decode of the command on the input port
        logic  more_dn;  // insert shift still has entries to move
        logic  more_up;  // delete shift still has entries to move
        logic  out_free; // result register can take a new beat
    } dp_stat_t;

endpackage

FILE: rtl/deque_with_positional_ops.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_positional_ops
// Bounded double-ended queue of 32-bit words with push and pop at both ends
// and insert or delete at a 1-based position; one result beat per command.
//
//   Channel  Dir  tdata (low bit up)                  tuser
//   s_*      in   value[31:0], position[36:32], pad   op[2:0]
//   m_*      out  removed_value[31:0],                status[1:0]
//                 entry_count[36:32], pad
//
// Commands are handled one at a time. An insert or push, and a delete or
// pop, move each shifted entry with a read state and then a write state,
// since the entry memory is read through a register; a delete or pop first
// reads and captures the removed word. The next command is taken while a
// result beat still waits on m_tready; a result stalls in the controller
// only if the earlier beat has not yet gone.
// Reset empties the store at once.
// ----------------------------------------------------------------------------
module deque_with_positional_ops #(
    parameter int DEPTH = dqpos_pkg::DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], position[36:32], zero pad
    input  logic [2:0]  s_tuser,   // op[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // removed_value[31:0], entry_count[36:32], zero pad
    output logic [1:0]  m_tuser    // status[1:0]
);
    import dqpos_pkg::*;

    dp_cmd_t            cmd;
    dp_stat_t           stat;
    logic signed [31:0] removed_value;
    logic [4:0]         entry_count;

    // Sequencer for one command at a time.
    dqpos_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Store, decode and result register.
    dqpos_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (s_tuser),
        .value         (s_tdata[31:0]),
        .position      (s_tdata[36:32]),
        .cmd           (cmd),
        .stat          (stat),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .removed_value (removed_value),
        .status        (m_tuser),
        .entry_count   (entry_count)
    );

    // Pack the result beat.
    assign m_tdata = {3'b000, entry_count, removed_value};

endmodule

FILE: rtl/dqpos_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqpos_dp
// Datapath: command decode, entry memory, shift pointer, count and the
// result register.
// ----------------------------------------------------------------------------
module dqpos_dp #(
    parameter int DEPTH = dqpos_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [2:0]         op,
    input  logic signed [31:0] value,
    input  logic [4:0]         position,
    input  dqpos_pkg::dp_cmd_t cmd,
    output dqpos_pkg::dp_stat_t stat,
    input  logic               m_tready,
    output logic               m_tvalid,
    output logic signed [31:0] removed_value,
    output logic [1:0]         status,
    output logic [4:0]         entry_count
);
    import dqpos_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > 5) ? CW : 5) + 1;

    logic [31:0]   mem [DEPTH];
    logic [31:0]   rdata_reg;
    logic [31:0]   val_reg;
    logic [31:0]   removed_reg;
    st_t           status_reg;
    logic [AW-1:0] tgt_reg;
    logic [AW-1:0] ptr_reg;
    logic [AW-1:0] ptr_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          m_valid_reg;
    logic          m_valid_next;
    logic [31:0]   m_removed_reg;
    st_t           m_status_reg;
    logic [4:0]    m_count_reg;

    logic [XW-1:0] cnt_x;
    logic [XW-1:0] cnt_p1;
    logic [XW-1:0] cnt_m1;
    logic [XW-1:0] pos_x;
    logic [XW-1:0] pos_m1;
    logic [XW-1:0] depth_x;
    logic [XW-1:0] ptr_p1_x;
    kind_t         dec_kind;
    st_t           dec_status;
    logic [AW-1:0] dec_tgt;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    // Widened copies for range checks.
    assign cnt_x    = XW'(cnt_reg);
    assign cnt_p1   = cnt_x + XW'(1);
    assign cnt_m1   = cnt_x - XW'(1);
    assign pos_x    = XW'(position);
    assign pos_m1   = pos_x - XW'(1);
    assign depth_x  = XW'(DEPTH);
    assign ptr_p1_x = XW'(ptr_reg) + XW'(1);

    // Decode of the command on the input port against the current count.
    always_comb
    begin
        dec_kind   = KIND_NONE;
        dec_status = ST_OK;
        dec_tgt    = '0;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (cnt_x == depth_x)
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    dec_kind = KIND_INS;
                    dec_tgt  = (op == OP_PUSH_FRONT) ? '0 : cnt_x[AW-1:0];
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (cnt_x == '0)
                begin
                    dec_status = ST_EMPTY;
                end
                else
                begin
                    dec_kind = KIND_DEL;
                    dec_tgt  = (op == OP_POP_FRONT) ? '0 : cnt_m1[AW-1:0];
                end
            end
            OP_INSERT_AT:
            begin
                if (cnt_x == depth_x)
                begin
                    dec_status = ST_FULL;
                end
                else if (cnt_x == '0)
                begin
                    dec_kind = KIND_INS;
                end
                else if (pos_x == '0 || pos_x > cnt_p1)
                begin
                    dec_status = ST_RANGE;
                end
                else
                begin
                    dec_kind = KIND_INS;
                    dec_tgt  = pos_m1[AW-1:0];
                end
            end
            OP_DELETE_AT:
            begin
                if (cnt_x == '0)
                begin
                    dec_status = ST_EMPTY;
                end
                else if (pos_x == '0 || pos_x > cnt_x)
                begin
                    dec_status = ST_RANGE;
                end
                else
                begin
                    dec_kind = KIND_DEL;
                    dec_tgt  = pos_m1[AW-1:0];
                end
            end
            default:
            begin
                dec_kind = KIND_NONE;
            end
        endcase
    end

    // Status back to the controller.
    assign stat.kind     = dec_kind;
    assign stat.more_dn  = (ptr_reg > tgt_reg);
    assign stat.more_up  = (ptr_p1_x < cnt_x);
    assign stat.out_free = !m_valid_reg || m_tready;

    // Shift pointer: starts at the count for an insert, at the target for a delete.
    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.load)
        begin
            ptr_next = (dec_kind == KIND_INS) ? cnt_x[AW-1:0] : dec_tgt;
        end
        else if (cmd.wr_dn)
        begin
            ptr_next = ptr_reg - AW'(1);
        end
        else if (cmd.wr_up)
        begin
            ptr_next = ptr_p1_x[AW-1:0];
        end
    end

    // Entry count.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.put)
        begin
            cnt_next = cnt_p1[CW-1:0];
        end
        else if (cmd.dec_cnt)
        begin
            cnt_next = cnt_m1[CW-1:0];
        end
    end

    // Result register: filled on emit, emptied when the beat is taken.
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (cmd.emit)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers of the command in flight and of the result.
    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (cmd.load)
        begin
            val_reg     <= value;
            tgt_reg     <= dec_tgt;
            status_reg  <= dec_status;
            removed_reg <= '0;
        end
        else if (cmd.cap)
        begin
            removed_reg <= rdata_reg;
        end
        if (cmd.emit)
        begin
            m_removed_reg <= removed_reg;
            m_status_reg  <= status_reg;
            m_count_reg   <= cnt_x[4:0];
        end
    end

    // Entry memory: one write and one registered read port.
    assign mem_we    = cmd.wr_dn || cmd.wr_up || cmd.put;
    assign mem_waddr = cmd.put ? tgt_reg : ptr_reg;
    assign mem_wdata = cmd.put ? val_reg : rdata_reg;
    assign mem_re    = cmd.rd_dn || cmd.rd_up || cmd.rd_tgt;

    always_comb
    begin
        if (cmd.rd_dn)
        begin
            mem_raddr = ptr_reg - AW'(1);
        end
        else if (cmd.rd_up)
        begin
            mem_raddr = ptr_p1_x[AW-1:0];
        end
        else
        begin
            mem_raddr = tgt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign m_tvalid      = m_valid_reg;
    assign removed_value = m_removed_reg;
    assign status        = m_status_reg;
    assign entry_count   = m_count_reg;

`ifndef SYNTHESIS
    // The count never passes the capacity.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_x <= depth_x)
        else $error("entry count above capacity");

    // Placing a word raises the count by exactly one.
    a_put_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.put |=> cnt_reg == $past(cnt_p1[CW-1:0]))
        else $error("count not raised by put");

    // A downward shift writes only above the target.
    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_dn |-> ptr_reg > tgt_reg)
        else $error("insert shift outside its range");

    // A failed command never reports a removed word.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_status_reg != ST_OK) |-> m_removed_reg == '0)
        else $error("removed word on a failed command");
`endif

endmodule

FILE: rtl/dqpos_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqpos_ctrl
// Controller: sequences the entry shifts of one command at a time.
// ----------------------------------------------------------------------------
module dqpos_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  dqpos_pkg::dp_stat_t stat,
    output dqpos_pkg::dp_cmd_t  cmd
);
    import dqpos_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (stat.kind)
                        KIND_INS: state_next = S_INS_RD;
                        KIND_DEL: state_next = S_DEL_RD;
                        default:  state_next = S_EMIT;
                    endcase
                end
            end
            S_INS_RD:  state_next = stat.more_dn ? S_INS_WR : S_PUT;
            S_INS_WR:  state_next = S_INS_RD;
            S_PUT:     state_next = S_EMIT;
            S_DEL_RD:  state_next = S_DEL_CAP;
            S_DEL_CAP: state_next = S_SH_RD;
            S_SH_RD:   state_next = stat.more_up ? S_SH_WR : S_DEL_END;
            S_SH_WR:   state_next = S_SH_RD;
            S_DEL_END: state_next = S_EMIT;
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_INS_RD:  cmd.rd_dn   = stat.more_dn;
            S_INS_WR:  cmd.wr_dn   = 1'b1;
            S_PUT:     cmd.put     = 1'b1;
            S_DEL_RD:  cmd.rd_tgt  = 1'b1;
            S_DEL_CAP: cmd.cap     = 1'b1;
            S_SH_RD:   cmd.rd_up   = stat.more_up;
            S_SH_WR:   cmd.wr_up   = 1'b1;
            S_DEL_END: cmd.dec_cnt = 1'b1;
            S_EMIT:    cmd.emit    = stat.out_free;
            default:   cmd         = '0;
        endcase
    end

`ifndef SYNTHESIS
    // An insert shift step always follows a read of the entry below.
    a_ins_pair: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_dn |-> $past(cmd.rd_dn))
        else $error("insert write without a read");

    // A delete shift step always follows a read of the entry above.
    a_del_pair: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_up |-> $past(cmd.rd_up))
        else $error("delete write without a read");

    // A result is emitted only once the result register can take it.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result emitted over a waiting beat");
`endif

endmodule

FILE: verif/deque_with_positional_ops_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_positional_ops_tb
// Self-checking bench for the positional deque. Commands go in on the slave
// stream and a shadow deque in the bench predicts each result beat. Every
// beat on the master stream is compared field by field with the oldest
// prediction. Directed tests cover the empty, full and out-of-range cases.
// A back-pressure test holds the receiver off while commands keep coming,
// and random traffic follows in fill-biased and drain-biased runs.
// ----------------------------------------------------------------------------
module deque_with_positional_ops_tb;

    import dqpos_pkg::*;

    localparam int DQ_DEPTH = DEPTH_DEFAULT;

    // Op codes that the block ignores.
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    // Word values at the extremes of the signed range.
    localparam logic [31:0] VAL_MIN  = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_ZERO = 32'h0000_0000;
    localparam logic [31:0] VAL_NEG1 = 32'hFFFF_FFFF;

    // Cycles to wait once no result is outstanding: longest delete plus margin.
    localparam int SETTLE_CYCLES = 2 * DQ_DEPTH + 32;

    // One predicted result beat.
    typedef struct packed {
        logic [31:0] removed;
        logic [1:0]  status;
        logic [4:0]  count;
    } dq_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // value[31:0], position[36:32], zero pad
    logic [2:0]  s_tuser = '0;   // op[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // removed_value[31:0], entry_count[36:32], zero pad
    logic [1:0]  m_tuser;        // status[1:0]

    // Shadow copy of the stored words, front first, and pending predictions.
    logic [31:0] shadow_q[$];
    dq_result_t  expected_q[$];

    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    int hold_request = 0;
    int hold_left = 0;
    int stall_left = 0;

    int n_sent = 0;
    int n_checked = 0;
    int n_errors = 0;
    int status_seen[4] = '{0, 0, 0, 0};

    deque_with_positional_ops #(
        .DEPTH(DQ_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #2 clk = ~clk;

    // Apply one command to the shadow deque and return the result it gives.
    function automatic dq_result_t predict_cmd(input logic [2:0] op, input logic [31:0] val,
                                               input logic [4:0] pos);
        dq_result_t res;
        int         fill;
        res.removed = VAL_ZERO;
        res.status  = ST_OK;
        fill = shadow_q.size();
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (fill >= DQ_DEPTH)
                    res.status = ST_FULL;
                else if (op == OP_PUSH_FRONT)
                    shadow_q.push_front(val);
                else
                    shadow_q.push_back(val);
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (fill == 0)
                    res.status = ST_EMPTY;
                else if (op == OP_POP_FRONT)
                    res.removed = shadow_q.pop_front();
                else
                    res.removed = shadow_q.pop_back();
            end
            OP_INSERT_AT:
            begin
                // An empty store takes the word whatever the position.
                if (fill >= DQ_DEPTH)
                    res.status = ST_FULL;
                else if (fill == 0)
                    shadow_q.push_back(val);
                else if (pos < 1 || pos > fill + 1)
                    res.status = ST_RANGE;
                else
                    shadow_q.insert(pos - 1, val);
            end
            OP_DELETE_AT:
            begin
                if (fill == 0)
                    res.status = ST_EMPTY;
                else if (pos < 1 || pos > fill)
                    res.status = ST_RANGE;
                else
                begin
                    res.removed = shadow_q[pos - 1];
                    shadow_q.delete(pos - 1);
                end
            end
            default:
            begin
            end
        endcase
        res.count = 5'(shadow_q.size());
        return res;
    endfunction

    // Offer one command beat, wait for it to be taken and record its result.
    task automatic send_cmd(input logic [2:0] op, input logic [31:0] val, input logic [4:0] pos);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, pos, val};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_q.push_back(predict_cmd(op, val, pos));
        n_sent++;
    endtask

    // Stop sending and wait until every predicted beat has arrived.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver: a requested long hold, random stall bursts, otherwise ready.
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (stall_left != 0)
        begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (rx_idle_on && $urandom_range(0, 5) == 0)
        begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(1, 18) - 1;
        end
        else
            m_tready <= 1'b1;
    end

    // Compare every result beat with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        dq_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected result beat, expected none, actual %h/%h",
                         $time, m_tdata, m_tuser);
            end
            else
            begin
                want = expected_q.pop_front();
                n_checked++;
                status_seen[m_tuser]++;
                if (m_tdata[31:0] !== want.removed)
                begin
                    n_errors++;
                    $display("%0t: removed_value mismatch, expected %h, actual %h",
                             $time, want.removed, m_tdata[31:0]);
                end
                if (m_tuser !== want.status)
                begin
                    n_errors++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, m_tuser);
                end
                if (m_tdata[36:32] !== want.count)
                begin
                    n_errors++;
                    $display("%0t: entry_count mismatch, expected %0d, actual %0d",
                             $time, want.count, m_tdata[36:32]);
                end
            end
        end
    end

    // Empty store: pops and deletes refused, inserts at any position, last entry removed.
    task automatic test_empty_store();
        send_cmd(OP_POP_FRONT, VAL_ZERO, 5'd0);
        send_cmd(OP_POP_BACK, VAL_ZERO, 5'd0);
        send_cmd(OP_DELETE_AT, VAL_ZERO, 5'd1);
        send_cmd(OP_INSERT_AT, VAL_MIN, 5'd0);
        send_cmd(OP_DELETE_AT, VAL_ZERO, 5'd0);
        send_cmd(OP_DELETE_AT, VAL_ZERO, 5'd2);
        send_cmd(OP_INSERT_AT, VAL_NEG1, 5'd3);
        send_cmd(OP_POP_BACK, VAL_ZERO, 5'd31);
        send_cmd(OP_INSERT_AT, VAL_MAX, 5'd17);
        send_cmd(OP_DELETE_AT, VAL_ZERO, 5'd1);
    endtask

    // Fill to capacity through every insert path, then probe the full store.
    task automatic test_fill_to_full();
        int i;
        send_cmd(OP_PUSH_BACK, VAL_MAX, 5'd0);
        send_cmd(OP_PUSH_FRONT, VAL_MIN, 5'd0);
        send_cmd(OP_INSERT_AT, VAL_ZERO, 5'd2);
        send_cmd(OP_INSERT_AT, VAL_NEG1, 5'd4);
        for (i = 0; i < DQ_DEPTH - 4; i++)
        begin
            case (i % 3)
                0: send_cmd(OP_PUSH_FRONT, $urandom, 5'd0);
                1: send_cmd(OP_PUSH_BACK, $urandom, 5'd0);
                default: send_cmd(OP_INSERT_AT, $urandom, 5'($urandom_range(2, 5 + i)));
            endcase
        end
        send_cmd(OP_PUSH_BACK, $urandom, 5'd0);
        send_cmd(OP_PUSH_FRONT, $urandom, 5'd0);
        send_cmd(OP_INSERT_AT, $urandom, 5'd0);
        send_cmd(OP_DELETE_AT, VAL_ZERO, 5'd17);
        send_cmd(OP_DELETE_AT, VAL_ZERO, 5'd16);
        send_cmd(OP_POP_FRONT, VAL_ZERO, 5'd0);
        send_cmd(OP_UNUSED_6, $urandom, 5'd5);
        send_cmd(OP_UNUSED_7, $urandom, 5'd5);
    endtask

    // Random commands in runs that lean towards filling or draining the store.
    task automatic test_random_mix(input int n_cmds);
        int          done;
        int          run_left;
        int          fill_bias;
        int          fill;
        logic [2:0]  op;
        logic [31:0] val;
        logic [4:0]  pos;
        done = 0;
        run_left = 0;
        fill_bias = 50;
        while (done < n_cmds)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(10, 60);
                fill_bias = $urandom_range(10, 90);
            end
            fill = shadow_q.size();
            if ($urandom_range(0, 99) < 2)
                op = $urandom_range(0, 1) ? OP_UNUSED_7 : OP_UNUSED_6;
            else if ($urandom_range(0, 99) < fill_bias)
            begin
                case ($urandom_range(0, 2))
                    0: op = OP_PUSH_FRONT;
                    1: op = OP_PUSH_BACK;
                    default: op = OP_INSERT_AT;
                endcase
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: op = OP_POP_FRONT;
                    1: op = OP_POP_BACK;
                    default: op = OP_DELETE_AT;
                endcase
            end
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: val = VAL_MIN;
                    1: val = VAL_MAX;
                    2: val = VAL_ZERO;
                    default: val = VAL_NEG1;
                endcase
            end
            else
                val = $urandom;
            // Mostly legal positions, with some taken from the whole field.
            if ($urandom_range(0, 99) < 15)
                pos = 5'($urandom_range(0, 31));
            else if (op == OP_INSERT_AT)
                pos = 5'($urandom_range(1, fill + 1));
            else if (op == OP_DELETE_AT)
                pos = 5'($urandom_range(1, (fill > 0) ? fill : 1));
            else
                pos = 5'($urandom_range(0, 31));
            send_cmd(op, val, pos);
            if (op != OP_UNUSED_6 && op != OP_UNUSED_7)
                done++;
            run_left--;
        end
    endtask

    // Hold the receiver off while commands keep coming, then pause for all results.
    task automatic test_backpressure();
        bit saved_idle;
        saved_idle = tx_idle_on;
        tx_idle_on = 1'b0;
        hold_request = 300;
        test_random_mix(30);
        tx_idle_on = saved_idle;
        drain_results();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        test_empty_store();
        test_fill_to_full();
        drain_results();
        test_backpressure();
        test_random_mix(1260);
        drain_results();

        // Closing stretch at full rate on both sides.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_mix(300);
        drain_results();

        $display("Ran %0d commands with push, pop, insert and delete at empty, full and",
                 n_sent);
        $display("partial fill; %0d results checked, status ok/empty/full/range %0d/%0d/%0d/%0d.",
                 n_checked, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (n_errors == 0 && expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
